>>> rtl/fsbm_pkg.sv
// Shared types, constants and helper functions for the fuzzy subsequence matcher.
// Used by every module of the block but fsbm_query_store; depends on nothing else.
package fsbm_pkg;

    localparam int QUERY_CAPACITY = 32;
    localparam int QLEN_W         = $clog2(QUERY_CAPACITY + 1);
    localparam int QIDX_W         = $clog2(QUERY_CAPACITY);
    localparam int CHAR_W         = 8;
    localparam int POS_W          = 8;
    localparam int GAP_W          = 8;
    localparam int INDEX_W        = 12;

    localparam logic [POS_W-1:0]   NAME_LENGTH_MAX = POS_W'(255);
    localparam logic [GAP_W-1:0]   GAP_LIMIT       = {GAP_W{1'b1}};
    localparam int                 LIST_ENTRIES_MAX = 4096;
    localparam int                 ENTRY_LAST_INT   =
        (LIST_ENTRIES_MAX - 1 < (1 << INDEX_W) - 1) ? LIST_ENTRIES_MAX - 1
                                                    : (1 << INDEX_W) - 1;
    localparam logic [INDEX_W-1:0] ENTRY_LAST = INDEX_W'(ENTRY_LAST_INT);

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_CHAR   = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAR_W-1:0] char_code;
        logic              list_end;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_W-1:0] entry_index;
        logic               matched;
        logic [GAP_W-1:0]   gap_score;
        logic               list_done;
        logic               best_found;
        logic [INDEX_W-1:0] best_entry_index;
    } t_out_word;

    typedef struct packed {
        logic              en;
        logic [QIDX_W-1:0] addr;
        logic [CHAR_W-1:0] data;
    } t_qs_write;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_W'(8'h41) && c <= CHAR_W'(8'h5A)) begin
            r = c | CHAR_W'(8'h20);
        end
        return r;
    endfunction

endpackage

>>> rtl/fsbm_query_store.sv
// Generic single-port-write RAM with a registered read port; a write to the address
// being read shows its new data on the read port. Depends on nothing else.
module fsbm_query_store #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/fsbm_match_core.sv
// Query loading, candidate progress, list tracking and result formation for one word per cycle while i_exec is high.
// Depends on fsbm_pkg; reads the query through fsbm_query_store.
module fsbm_match_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_exec,
    input  fsbm_pkg::t_in_word             i_word,
    input  logic [fsbm_pkg::CHAR_W-1:0]    i_q_char,
    output logic [fsbm_pkg::QIDX_W-1:0]    o_q_rd_addr,
    output fsbm_pkg::t_qs_write            o_q_wr,
    output fsbm_pkg::t_out_word            o_result
);

    logic [fsbm_pkg::QLEN_W-1:0]  r_query_length, n_query_length;
    logic [fsbm_pkg::QLEN_W-1:0]  r_matched_count, n_matched_count;
    logic [fsbm_pkg::POS_W-1:0]   r_char_position, n_char_position;
    logic [fsbm_pkg::POS_W-1:0]   r_last_match_pos, n_last_match_pos;
    logic                         r_any_matched, n_any_matched;
    logic [fsbm_pkg::GAP_W-1:0]   r_gap_sum, n_gap_sum;
    logic [fsbm_pkg::INDEX_W-1:0] r_entry_counter, n_entry_counter;
    logic [fsbm_pkg::INDEX_W-1:0] r_best_entry, n_best_entry;
    logic [fsbm_pkg::GAP_W-1:0]   r_best_gap, n_best_gap;
    logic                         r_best_valid, n_best_valid;

    logic [fsbm_pkg::CHAR_W-1:0]  folded;
    logic                         hit;
    logic [fsbm_pkg::GAP_W-1:0]   score;
    logic                         take_best;
    logic [fsbm_pkg::POS_W-1:0]   skip;
    logic [fsbm_pkg::GAP_W:0]     gap_next;
    logic                         char_match;
    logic                         upd_best_valid;
    logic [fsbm_pkg::INDEX_W-1:0] upd_best_entry;

    // The store read is registered, so it is addressed with the next matched count.
    assign folded      = fsbm_pkg::fold_case(i_word.char_code);
    assign o_q_rd_addr = n_matched_count[fsbm_pkg::QIDX_W-1:0];
    assign char_match  = (r_matched_count < r_query_length) && (folded == i_q_char);
    assign skip        = r_char_position - r_last_match_pos - fsbm_pkg::POS_W'(1);
    assign gap_next    = {1'b0, r_gap_sum} + {1'b0, fsbm_pkg::GAP_W'(skip)};

    assign hit       = (r_matched_count == r_query_length);
    assign score     = hit ? r_gap_sum : '0;
    assign take_best = hit && (!r_best_valid || (score < r_best_gap));
    assign upd_best_valid = r_best_valid | hit;
    assign upd_best_entry = take_best ? r_entry_counter : r_best_entry;

    always_comb begin
        o_result.entry_index      = r_entry_counter;
        o_result.matched          = hit;
        o_result.gap_score        = score;
        o_result.list_done        = i_word.list_end;
        o_result.best_found       = upd_best_valid;
        o_result.best_entry_index = upd_best_valid ? upd_best_entry : '0;
    end

    always_comb begin
        o_q_wr.en   = 1'b0;
        o_q_wr.addr = r_query_length[fsbm_pkg::QIDX_W-1:0];
        o_q_wr.data = folded;

        n_query_length   = r_query_length;
        n_matched_count  = r_matched_count;
        n_char_position  = r_char_position;
        n_last_match_pos = r_last_match_pos;
        n_any_matched    = r_any_matched;
        n_gap_sum        = r_gap_sum;
        n_entry_counter  = r_entry_counter;
        n_best_entry     = r_best_entry;
        n_best_gap       = r_best_gap;
        n_best_valid     = r_best_valid;

        if (i_exec) begin
            case (i_word.kind)
                fsbm_pkg::KIND_CLEAR,
                fsbm_pkg::KIND_APPEND: begin
                    if (i_word.kind == fsbm_pkg::KIND_CLEAR) begin
                        n_query_length = '0;
                    end else if (r_query_length <
                                 fsbm_pkg::QLEN_W'(fsbm_pkg::QUERY_CAPACITY)) begin
                        o_q_wr.en      = 1'b1;
                        n_query_length = r_query_length + fsbm_pkg::QLEN_W'(1);
                    end
                    n_matched_count  = '0;
                    n_char_position  = '0;
                    n_last_match_pos = '0;
                    n_any_matched    = 1'b0;
                    n_gap_sum        = '0;
                    n_entry_counter  = '0;
                    n_best_entry     = '0;
                    n_best_gap       = '0;
                    n_best_valid     = 1'b0;
                end
                fsbm_pkg::KIND_CHAR: begin
                    if (r_char_position < fsbm_pkg::NAME_LENGTH_MAX) begin
                        if (char_match) begin
                            if (r_any_matched) begin
                                n_gap_sum = gap_next[fsbm_pkg::GAP_W] ? fsbm_pkg::GAP_LIMIT
                                                : gap_next[fsbm_pkg::GAP_W-1:0];
                            end
                            n_last_match_pos = r_char_position;
                            n_any_matched    = 1'b1;
                            n_matched_count  = r_matched_count + fsbm_pkg::QLEN_W'(1);
                        end
                        n_char_position = r_char_position + fsbm_pkg::POS_W'(1);
                    end
                end
                fsbm_pkg::KIND_END: begin
                    n_matched_count  = '0;
                    n_char_position  = '0;
                    n_last_match_pos = '0;
                    n_any_matched    = 1'b0;
                    n_gap_sum        = '0;
                    if (i_word.list_end) begin
                        n_entry_counter = '0;
                        n_best_entry    = '0;
                        n_best_gap      = '0;
                        n_best_valid    = 1'b0;
                    end else begin
                        n_best_valid = upd_best_valid;
                        n_best_entry = upd_best_entry;
                        if (take_best) begin
                            n_best_gap = score;
                        end
                        if (r_entry_counter != fsbm_pkg::ENTRY_LAST) begin
                            n_entry_counter = r_entry_counter + fsbm_pkg::INDEX_W'(1);
                        end
                    end
                end
                default: begin
                    n_query_length = r_query_length;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_length   <= '0;
            r_matched_count  <= '0;
            r_char_position  <= '0;
            r_last_match_pos <= '0;
            r_any_matched    <= 1'b0;
            r_gap_sum        <= '0;
            r_entry_counter  <= '0;
            r_best_entry     <= '0;
            r_best_gap       <= '0;
            r_best_valid     <= 1'b0;
        end else begin
            r_query_length   <= n_query_length;
            r_matched_count  <= n_matched_count;
            r_char_position  <= n_char_position;
            r_last_match_pos <= n_last_match_pos;
            r_any_matched    <= n_any_matched;
            r_gap_sum        <= n_gap_sum;
            r_entry_counter  <= n_entry_counter;
            r_best_entry     <= n_best_entry;
            r_best_gap       <= n_best_gap;
            r_best_valid     <= n_best_valid;
        end
    end

endmodule

>>> rtl/fuzzy_subsequence_best_match.sv
// Top level of the fuzzy subsequence best-match block: input and result registers.
// Depends on fsbm_pkg, fsbm_query_store and fsbm_match_core.
//
//   Channel | Direction | Handshake               | Word
//   input   | in        | i_in_valid / o_in_ready | i_in_word (t_in_word)
//   result  | out       | o_out_valid/i_out_ready | o_out_word (t_out_word)
//
// Each input word is executed from the input register, so one word is accepted per
// cycle unless an end-of-candidate word waits on a stalled result; an end-of-candidate
// word shows its result in the cycle after execution. The rate is set by the single
// match compare against the query store read port. Reset is synchronous and clears all
// control state; the query store contents are not cleared. A stalled result holds back
// only end-of-candidate words; other words flow on until one of those is waiting.
module fuzzy_subsequence_best_match (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fsbm_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fsbm_pkg::t_out_word  o_out_word
);

    logic                         r_in_valid;
    fsbm_pkg::t_in_word           r_in_word;
    logic                         r_out_valid;
    fsbm_pkg::t_out_word          r_out_word;

    logic                         out_free;
    logic                         is_end;
    logic                         exec;
    fsbm_pkg::t_qs_write          q_wr;
    logic [fsbm_pkg::QIDX_W-1:0]  q_rd_addr;
    logic [fsbm_pkg::CHAR_W-1:0]  q_char;
    fsbm_pkg::t_out_word          result;

    assign out_free   = !r_out_valid || i_out_ready;
    assign is_end     = (r_in_word.kind == fsbm_pkg::KIND_END);
    assign exec       = r_in_valid && (!is_end || out_free);
    assign o_in_ready = !r_in_valid || exec;

    fsbm_query_store #(
        .WIDTH (fsbm_pkg::CHAR_W),
        .DEPTH (fsbm_pkg::QUERY_CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (q_wr.en),
        .i_wr_addr (q_wr.addr),
        .i_wr_data (q_wr.data),
        .i_rd_addr (q_rd_addr),
        .o_rd_data (q_char)
    );

    fsbm_match_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_exec      (exec),
        .i_word      (r_in_word),
        .i_q_char    (q_char),
        .o_q_rd_addr (q_rd_addr),
        .o_q_wr      (q_wr),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (exec && is_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (exec && is_end) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> rtl/fsbm_checker.sv
// Port-level checks for the fuzzy subsequence best-match block, bound to its top level.
// Depends on fsbm_pkg and the top level fuzzy_subsequence_best_match.
module fsbm_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  fsbm_pkg::t_out_word  o_out_word
);

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    a_miss_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.matched |-> o_out_word.gap_score == '0)
        else $error("unmatched candidate carries a score");

    a_match_sets_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.matched |-> o_out_word.best_found)
        else $error("matched candidate without a best entry");

    a_no_best_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.best_found |-> o_out_word.best_entry_index == '0)
        else $error("best index set without a best entry");

endmodule

bind fuzzy_subsequence_best_match fsbm_checker u_fsbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
